// File: design/bhms_pkg.sv
// ----------------------------------------------------------------------------
// bhms_pkg
// Shared types and constants for the button hold mode selector: register
// indexes, register widths, the configuration bundle and the result bundle.
// ----------------------------------------------------------------------------
package bhms_pkg;

  localparam int REG_W     = 26;
  localparam int SCOPE_W   = 8;
  localparam int CHOICE_W  = 8;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_SCOPE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 3'd4;

  localparam logic [SCOPE_W-1:0]  SCOPE_RST    = 8'd0;
  localparam logic [REG_W-1:0]    STEP_RST     = 26'd750000;
  localparam logic [REG_W-1:0]    PERIOD_RST   = 26'd1000000;
  localparam logic [REG_W-1:0]    HOLD_RST     = 26'd50000000;
  localparam logic [REG_W-1:0]    DEBOUNCE_RST = 26'd1000000;
  localparam logic [CHOICE_W-1:0] CHOICE_NONE  = 8'hFF;

  // led bit positions
  localparam int LED_R = 0;
  localparam int LED_Y = 1;
  localparam int LED_G = 2;

  typedef struct packed {
    logic [SCOPE_W-1:0] scope;
    logic [REG_W-1:0]   step_ticks;
    logic [REG_W-1:0]   period_ticks;
    logic [REG_W-1:0]   hold_ticks;
    logic [REG_W-1:0]   debounce_ticks;
  } cfg_t;

  typedef struct packed {
    logic [CHOICE_W-1:0] choice;
    logic                led_red;
    logic                led_yellow;
    logic                led_green;
    logic                selecting;
    logic                soft_reset;
    logic                hard_reset;
  } res_t;

endpackage

// File: design/bhms_cfg_regs.sv
// ----------------------------------------------------------------------------
// bhms_cfg_regs
// Configuration register file: decodes register writes and flags scope writes.
// ----------------------------------------------------------------------------
module bhms_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bhms_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bhms_pkg::REG_W-1:0]    cfg_data,
  output bhms_pkg::cfg_t                cfg,
  output logic                          scope_wr
);
  import bhms_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scope          <= SCOPE_RST;
      cfg.step_ticks     <= STEP_RST;
      cfg.period_ticks   <= PERIOD_RST;
      cfg.hold_ticks     <= HOLD_RST;
      cfg.debounce_ticks <= DEBOUNCE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCOPE:    cfg.scope          <= cfg_data[SCOPE_W-1:0];
        REG_STEP:     cfg.step_ticks     <= cfg_data;
        REG_PERIOD:   cfg.period_ticks   <= cfg_data;
        REG_HOLD:     cfg.hold_ticks     <= cfg_data;
        REG_DEBOUNCE: cfg.debounce_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  assign scope_wr = cfg_we && (cfg_index == REG_SCOPE);

endmodule

// File: design/bhms_fsm.sv
// ----------------------------------------------------------------------------
// bhms_fsm
// Selector state machine: holds phase, tick counter, choice and leds, and
// works out the next state and the result for one tick request.
// ----------------------------------------------------------------------------
module bhms_fsm #(
  parameter int COUNTER_WIDTH = 26
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  logic           pressed,
  input  logic           clear,
  input  bhms_pkg::cfg_t cfg,
  input  logic           scope_wr,
  output bhms_pkg::res_t res
);
  import bhms_pkg::*;

  localparam int CMP_W = (COUNTER_WIDTH > REG_W) ? COUNTER_WIDTH : REG_W;

  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_PRESS_DEB = 3'd1;
  localparam logic [2:0] PH_COUNT     = 3'd2;
  localparam logic [2:0] PH_REL_DEB   = 3'd3;
  localparam logic [2:0] PH_MENU      = 3'd4;
  localparam logic [2:0] PH_HARD_WAIT = 3'd5;
  localparam logic [2:0] PH_RESET_DEB = 3'd6;
  localparam logic [2:0] PH_HALT      = 3'd7;

  logic [2:0]               phase, phase_next;
  logic [COUNTER_WIDTH-1:0] tick_count, tick_count_next;
  logic [CHOICE_W-1:0]      choice_reg, choice_reg_next;
  logic [2:0]               led_bits, led_bits_next;
  logic                     soft_pulse, hard;

  logic [COUNTER_WIDTH-1:0] cnt;
  logic [CMP_W-1:0]         tick_ext, cnt_ext;
  logic                     deb_done, step_hit, period_hit, hold_hit;
  logic [CHOICE_W-1:0]      choice_inc;

  assign cnt        = tick_count + COUNTER_WIDTH'(1);
  assign tick_ext   = CMP_W'(tick_count);
  assign cnt_ext    = CMP_W'(cnt);
  assign deb_done   = !(tick_ext < CMP_W'(cfg.debounce_ticks));
  assign step_hit   = cnt_ext == CMP_W'(cfg.step_ticks);
  assign period_hit = cnt_ext == CMP_W'(cfg.period_ticks);
  assign hold_hit   = cnt_ext == CMP_W'(cfg.hold_ticks);
  assign choice_inc = choice_reg + CHOICE_W'(1);

  always_comb begin
    phase_next      = phase;
    tick_count_next = tick_count;
    choice_reg_next = choice_reg;
    led_bits_next   = led_bits;
    soft_pulse      = 1'b0;
    hard            = 1'b0;
    unique case (phase)
      PH_IDLE: begin
        if (clear) choice_reg_next = CHOICE_NONE;
        if (pressed) begin
          phase_next      = PH_PRESS_DEB;
          tick_count_next = '0;
        end
      end
      PH_PRESS_DEB: begin
        tick_count_next = deb_done ? '0 : cnt;
        if (deb_done) begin
          led_bits_next[LED_Y] = 1'b0;
          choice_reg_next      = '0;
          phase_next           = PH_COUNT;
        end
      end
      PH_COUNT: begin
        if (step_hit && (choice_inc > cfg.scope)) begin
          choice_reg_next      = choice_inc;
          led_bits_next[LED_Y] = 1'b1;
          led_bits_next[LED_R] = 1'b0;
          led_bits_next[LED_G] = 1'b0;
          tick_count_next      = '0;
          phase_next           = PH_MENU;
        end else begin
          if (step_hit) begin
            choice_reg_next      = choice_inc;
            led_bits_next[LED_Y] = 1'b1;
          end
          tick_count_next = cnt;
          if (period_hit) begin
            led_bits_next[LED_Y] = 1'b0;
            tick_count_next      = '0;
          end
          if (!pressed) begin
            phase_next      = PH_REL_DEB;
            tick_count_next = '0;
          end
        end
      end
      PH_REL_DEB: begin
        tick_count_next = deb_done ? '0 : cnt;
        if (deb_done) begin
          led_bits_next[LED_Y] = 1'b0;
          phase_next           = PH_IDLE;
        end
      end
      PH_MENU: begin
        if (!pressed) begin
          phase_next      = PH_RESET_DEB;
          tick_count_next = '0;
        end else begin
          tick_count_next = cnt;
          if (hold_hit) begin
            led_bits_next = 3'b111;
            phase_next    = PH_HARD_WAIT;
          end
        end
      end
      PH_HARD_WAIT: begin
        if (!pressed) begin
          phase_next      = PH_RESET_DEB;
          tick_count_next = '0;
        end
      end
      PH_RESET_DEB: begin
        // red is lit only on the hard path
        tick_count_next = deb_done ? '0 : cnt;
        if (deb_done) begin
          hard       = led_bits[LED_R];
          soft_pulse = !led_bits[LED_R];
          phase_next = PH_HALT;
        end
      end
      PH_HALT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      tick_count <= '0;
      choice_reg <= CHOICE_NONE;
      led_bits   <= '0;
    end else begin
      if (step) begin
        phase      <= phase_next;
        tick_count <= tick_count_next;
        led_bits   <= led_bits_next;
      end
      if (scope_wr) begin
        choice_reg <= CHOICE_NONE;
      end else if (step) begin
        choice_reg <= choice_reg_next;
      end
    end
  end

  always_comb begin
    res.choice     = choice_reg_next;
    res.led_red    = led_bits_next[LED_R];
    res.led_yellow = led_bits_next[LED_Y];
    res.led_green  = led_bits_next[LED_G];
    res.selecting  = (phase_next != PH_IDLE) && (phase_next != PH_HALT);
    res.soft_reset = soft_pulse;
    res.hard_reset = hard;
  end

`ifndef SYNTHESIS
  a_halt_sticks: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HALT |=> phase == PH_HALT)
    else $error("left halt without reset");

  a_pulse_halts: assert property (@(posedge clk) disable iff (rst)
    step && (soft_pulse || hard) |=> phase == PH_HALT)
    else $error("reset pulse without halt");

  a_hard_needs_red: assert property (@(posedge clk) disable iff (rst)
    step && hard |-> led_bits[LED_R] && phase == PH_RESET_DEB)
    else $error("hard reset off the hard path");

  a_menu_leds: assert property (@(posedge clk) disable iff (rst)
    step && phase == PH_COUNT && phase_next == PH_MENU |=>
      !led_bits[LED_R] && !led_bits[LED_G] && led_bits[LED_Y])
    else $error("menu entry leds wrong");
`endif

endmodule

// File: design/button_hold_mode_selector_core.sv
// ----------------------------------------------------------------------------
// button_hold_mode_selector_core
// Push-button mode selector with hold-to-reset menu, one tick per request.
// ----------------------------------------------------------------------------
// Each input request is one tick carrying the button level and a clear flag;
// each produces exactly one result request with the choice, the three led
// drives, the selecting flag and the one-tick soft/hard reset pulses. The
// block takes one request per clock unless m_tready stalls the result;
// each request passes the input register, then the state machine update
// and the counter compares, then the result register. The user must write
// registers through cfg_we/cfg_index/cfg_data only while the block is idle;
// the block does not enforce it. A scope write also sets the choice to 255.
module button_hold_mode_selector_core #(
  parameter int COUNTER_WIDTH = 26
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // button_pressed, clear_choice
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [15:0]                    m_tdata,   // choice[7:0], led_red, led_yellow,
                                                    // led_green, selecting, soft_reset,
                                                    // hard_reset
  input  logic                           cfg_we,
  input  logic [bhms_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bhms_pkg::REG_W-1:0]     cfg_data
);
  import bhms_pkg::*;

  cfg_t cfg;
  logic scope_wr;
  res_t res, out_res;

  logic in_valid, in_pressed, in_clear;
  logic advance;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_pressed <= s_tdata[0];
      in_clear   <= s_tdata[1];
    end
  end

  bhms_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .scope_wr  (scope_wr)
  );

  bhms_fsm #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_fsm (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .pressed  (in_pressed),
    .clear    (in_clear),
    .cfg      (cfg),
    .scope_wr (scope_wr),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_tdata = {2'b00, out_res.hard_reset, out_res.soft_reset, out_res.selecting,
                    out_res.led_green, out_res.led_yellow, out_res.led_red,
                    out_res.choice};

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of the button hold mode selector. A directed table walks
// press, debounce, counting, release on the entry tick and clear; random
// phases then push press/release runs with bounce noise through several
// register settings, extremes among them. A final phase enters the reset menu
// and takes the soft or the hard path into the halt state. Every result
// request is compared field by field with an in-bench prediction.
// ----------------------------------------------------------------------------
module testbench;
  import bhms_pkg::*;

  localparam int CNT_W = 26;
  localparam logic [REG_W-1:0] REG_MAX = {REG_W{1'b1}};
  localparam res_t IDLE_RES = '{CHOICE_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};

  typedef enum logic [2:0] {
    ST_IDLE, ST_PRESS_DEB, ST_COUNT, ST_REL_DEB,
    ST_MENU, ST_HARD_WAIT, ST_RESET_DEB, ST_HALT
  } sel_phase_e;

  typedef struct packed {
    sel_phase_e           phase;
    logic [CNT_W-1:0]     cnt;
    logic [CHOICE_W-1:0]  choice;
    logic [2:0]           leds;
  } sel_state_t;

  typedef struct packed {
    bit   pressed;
    bit   clear;
    bit   typed;
    res_t want;
  } row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [15:0]          m_tdata;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_SCOPE;
  logic [REG_W-1:0]     cfg_data = '0;

  button_hold_mode_selector_core #(.COUNTER_WIDTH(CNT_W)) u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  cfg_t        regs = '{SCOPE_RST, STEP_RST, PERIOD_RST, HOLD_RST, DEBOUNCE_RST};
  sel_state_t  sel = '{ST_IDLE, '0, CHOICE_NONE, 3'b000};
  res_t        choice_q[$];
  int          errors = 0;
  int          burst_left = 0;
  int          run_left = 0;
  bit          run_level = 1'b0;
  bit          presses_on = 1'b1;
  int unsigned press_lo = 1;
  int unsigned press_hi = 30;
  int unsigned rel_hi = 10;
  logic [7:0]  stall_tick = '0;
  logic [1:0]  stall_mode = '0;

  row_t directed_rows[21] = '{
    '{1'b0, 1'b0, 1'b1, IDLE_RES},
    '{1'b0, 1'b1, 1'b1, IDLE_RES},
    '{1'b1, 1'b0, 1'b0, res_t'(0)},
    '{1'b1, 1'b0, 1'b0, res_t'(0)},
    '{1'b1, 1'b0, 1'b0, res_t'(0)},
    '{1'b0, 1'b0, 1'b0, res_t'(0)},
    '{1'b0, 1'b0, 1'b0, res_t'(0)},
    '{1'b0, 1'b0, 1'b0, res_t'(0)},
    '{1'b0, 1'b1, 1'b1, IDLE_RES},
    '{1'b1, 1'b0, 1'b0, res_t'(0)},
    '{1'b1, 1'b0, 1'b0, res_t'(0)},
    '{1'b1, 1'b0, 1'b0, res_t'(0)},
    '{1'b1, 1'b0, 1'b0, res_t'(0)},
    '{1'b1, 1'b1, 1'b0, res_t'(0)},
    '{1'b1, 1'b0, 1'b0, res_t'(0)},
    '{1'b1, 1'b0, 1'b0, res_t'(0)},
    '{1'b1, 1'b0, 1'b0, res_t'(0)},
    '{1'b0, 1'b0, 1'b0, res_t'(0)},
    '{1'b1, 1'b0, 1'b0, res_t'(0)},
    '{1'b0, 1'b0, 1'b0, res_t'(0)},
    '{1'b0, 1'b0, 1'b0, res_t'(0)}
  };

  function automatic bit debounce_over(inout sel_state_t st);
    if (st.cnt < regs.debounce_ticks) begin
      st.cnt = st.cnt + 1'b1;
      return 1'b0;
    end
    st.cnt = '0;
    return 1'b1;
  endfunction

  // one tick of the selector, returns the result request it causes
  function automatic res_t advance(inout sel_state_t st, input bit pressed, input bit clear);
    logic [CNT_W-1:0] nxt;
    bit               to_menu;
    bit               soft_pulse;
    bit               hard;
    res_t             r;
    to_menu = 1'b0;
    soft_pulse = 1'b0;
    hard = 1'b0;
    case (st.phase)
      ST_IDLE: begin
        if (clear) st.choice = CHOICE_NONE;
        if (pressed) begin
          st.phase = ST_PRESS_DEB;
          st.cnt = '0;
        end
      end
      ST_PRESS_DEB: begin
        if (debounce_over(st)) begin
          st.leds[LED_Y] = 1'b0;
          st.choice = '0;
          st.phase = ST_COUNT;
        end
      end
      ST_COUNT: begin
        nxt = st.cnt + 1'b1;
        if (nxt == regs.step_ticks) begin
          st.choice = st.choice + 1'b1;
          st.leds[LED_Y] = 1'b1;
          if (st.choice > regs.scope) begin
            st.leds[LED_R] = 1'b0;
            st.leds[LED_G] = 1'b0;
            st.cnt = '0;
            st.phase = ST_MENU;
            to_menu = 1'b1;
          end
        end
        if (!to_menu) begin
          if (nxt == regs.period_ticks) begin
            st.leds[LED_Y] = 1'b0;
            nxt = '0;
          end
          st.cnt = nxt;
          if (!pressed) begin
            st.phase = ST_REL_DEB;
            st.cnt = '0;
          end
        end
      end
      ST_REL_DEB: begin
        if (debounce_over(st)) begin
          st.leds[LED_Y] = 1'b0;
          st.phase = ST_IDLE;
        end
      end
      ST_MENU: begin
        if (!pressed) begin
          st.phase = ST_RESET_DEB;
          st.cnt = '0;
        end else begin
          st.cnt = st.cnt + 1'b1;
          if (st.cnt == regs.hold_ticks) begin
            st.leds = 3'b111;
            st.phase = ST_HARD_WAIT;
          end
        end
      end
      ST_HARD_WAIT: begin
        if (!pressed) begin
          st.phase = ST_RESET_DEB;
          st.cnt = '0;
        end
      end
      ST_RESET_DEB: begin
        // red is lit only on the hard path
        if (debounce_over(st)) begin
          if (st.leds[LED_R]) hard = 1'b1;
          else soft_pulse = 1'b1;
          st.phase = ST_HALT;
        end
      end
      default: ;
    endcase
    r.choice = st.choice;
    r.led_red = st.leds[LED_R];
    r.led_yellow = st.leds[LED_Y];
    r.led_green = st.leds[LED_G];
    r.selecting = (st.phase != ST_IDLE) && (st.phase != ST_HALT);
    r.soft_reset = soft_pulse;
    r.hard_reset = hard;
    return r;
  endfunction

  // true when holding now would make the menu unavoidable on the next tick
  function automatic bit menu_near(sel_state_t st);
    sel_state_t t;
    res_t       r;
    t = st;
    r = advance(t, 1'b1, 1'b0);
    if (t.phase == ST_MENU) return 1'b1;
    r = advance(t, 1'b0, 1'b0);
    return t.phase == ST_MENU;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_request(input bit pressed, input bit clear, input bit typed,
                              input res_t want);
    res_t r;
    int   gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      burst_left = $urandom_range(1, 30);
      if (gap != 0) begin
        s_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_tvalid = 1'b1;
    s_tdata = {6'b0, clear, pressed};
    do @(posedge clk); while (!s_tready);
    r = advance(sel, pressed, clear);
    choice_q.push_back(typed ? want : r);
    @(negedge clk);
  endtask

  task automatic random_request(input bit guard);
    bit pressed;
    bit clear;
    if (run_left == 0) begin
      run_level = presses_on ? ~run_level : 1'b0;
      run_left = run_level ? $urandom_range(press_lo, press_hi) : $urandom_range(1, rel_hi);
    end
    run_left--;
    pressed = run_level;
    if (presses_on && $urandom_range(0, 11) == 0) pressed = ~pressed;
    clear = ($urandom_range(0, 3) == 0);
    if (guard && pressed && menu_near(sel)) pressed = 1'b0;
    send_request(pressed, clear, 1'b0, res_t'(0));
  endtask

  task automatic settle;
    s_tvalid = 1'b0;
    while (choice_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    case (idx)
      REG_SCOPE: begin
        regs.scope = data[SCOPE_W-1:0];
        sel.choice = CHOICE_NONE;
      end
      REG_STEP:     regs.step_ticks = data;
      REG_PERIOD:   regs.period_ticks = data;
      REG_HOLD:     regs.hold_ticks = data;
      REG_DEBOUNCE: regs.debounce_ticks = data;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic program_all(input int unsigned scope, input int unsigned step,
                             input int unsigned period, input int unsigned hold,
                             input int unsigned deb);
    settle();
    write_reg(REG_SCOPE, REG_W'(scope));
    write_reg(REG_STEP, REG_W'(step));
    write_reg(REG_PERIOD, REG_W'(period));
    write_reg(REG_HOLD, REG_W'(hold));
    write_reg(REG_DEBOUNCE, REG_W'(deb));
    cfg_we = 1'b0;
  endtask

  // enter the reset menu and leave it by the soft or the hard path
  task automatic run_reset_menu;
    bit hard_path;
    int menu_left;
    int hold_more;
    int unsigned step;
    bit pressed;
    hard_path = 1'($urandom_range(0, 1));
    step = $urandom_range(1, 3);
    program_all($urandom_range(0, 3), step, step + $urandom_range(0, 2),
                $urandom_range(1, 12), $urandom_range(0, 3));
    menu_left = $urandom_range(0, regs.hold_ticks - 1);
    hold_more = $urandom_range(0, 5);
    while (sel.phase != ST_HALT) begin
      case (sel.phase)
        ST_MENU: begin
          pressed = hard_path || (menu_left > 0);
          menu_left--;
        end
        ST_HARD_WAIT: begin
          pressed = (hold_more > 0);
          hold_more--;
        end
        ST_RESET_DEB: pressed = 1'($urandom_range(0, 1));
        default: pressed = 1'b1;
      endcase
      send_request(pressed, 1'($urandom_range(0, 1)), 1'b0, res_t'(0));
    end
    repeat (20) send_request(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0,
                             res_t'(0));
    settle();
    write_reg(REG_DEBOUNCE, REG_MAX);
    write_reg(REG_SCOPE, REG_W'($urandom_range(0, 255)));
    cfg_we = 1'b0;
    repeat (10) send_request(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0,
                             res_t'(0));
  endtask

  initial begin
    int unsigned n;
    int unsigned s;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    program_all(200, 2, 3, 5, 1);
    foreach (directed_rows[i])
      send_request(directed_rows[i].pressed, directed_rows[i].clear, directed_rows[i].typed,
                   directed_rows[i].want);

    for (int p = 0; p < 7; p++) begin
      presses_on = 1'b1;
      press_lo = 1;
      press_hi = 30;
      rel_hi = 10;
      n = 80;
      case (p)
        0: program_all($urandom_range(1, 20), $urandom_range(1, 6), $urandom_range(1, 8),
                       $urandom_range(1, 50), $urandom_range(0, 3));
        1: begin
          s = $urandom_range(1, 5);
          program_all($urandom_range(2, 10), s, s, $urandom_range(1, 50), $urandom_range(0, 3));
        end
        2: begin
          s = $urandom_range(1, 4);
          program_all($urandom_range(1, 255), s + $urandom_range(1, 6), s,
                      $urandom_range(1, 50), $urandom_range(0, 3));
        end
        3: begin
          // step and period of one tick: choice runs through 255 and wraps
          program_all(255, 1, 1, $urandom_range(1, 50), 0);
          press_lo = 250;
          press_hi = 320;
          rel_hi = 4;
          n = 350;
        end
        4: program_all(1, REG_MAX, REG_MAX, REG_MAX, 0);
        5: begin
          program_all($urandom_range(1, 255), $urandom_range(1, 6), $urandom_range(1, 8),
                      $urandom_range(1, 50), REG_MAX);
          presses_on = 1'b0;
        end
        default: program_all($urandom_range(1, 3), $urandom_range(1, 2), $urandom_range(1, 3),
                             $urandom_range(1, 50), $urandom_range(0, 2));
      endcase
      run_left = 0;
      run_level = 1'b0;
      repeat (n) random_request(1'b1);
      while (sel.phase != ST_IDLE)
        send_request(1'b0, 1'($urandom_range(0, 1)), 1'b0, res_t'(0));
    end

    run_reset_menu();

    s_tvalid = 1'b0;
    while (choice_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #5000000;
    $display("DONE: errors detected");
    $finish;
  end

  always @(negedge clk) begin
    stall_tick <= stall_tick + 1'b1;
    if (stall_tick[6:0] == 7'd0) stall_mode <= 2'($urandom_range(0, 3));
    case (stall_mode)
      2'd0: m_tready <= 1'b1;
      2'd1: m_tready <= 1'($urandom_range(0, 1));
      2'd2: m_tready <= (stall_tick[2:0] != 3'd0);
      default: m_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  res_t seen;
  res_t due;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen.choice = m_tdata[7:0];
      seen.led_red = m_tdata[8];
      seen.led_yellow = m_tdata[9];
      seen.led_green = m_tdata[10];
      seen.selecting = m_tdata[11];
      seen.soft_reset = m_tdata[12];
      seen.hard_reset = m_tdata[13];
      if (choice_q.size() == 0) begin
        $error("result request with nothing expected: %h", m_tdata);
        errors++;
      end else begin
        due = choice_q.pop_front();
        if (seen.choice !== due.choice) begin
          $error("choice: expected %0d, got %0d", due.choice, seen.choice);
          errors++;
        end
        if (seen.led_red !== due.led_red) begin
          $error("led_red: expected %0d, got %0d", due.led_red, seen.led_red);
          errors++;
        end
        if (seen.led_yellow !== due.led_yellow) begin
          $error("led_yellow: expected %0d, got %0d", due.led_yellow, seen.led_yellow);
          errors++;
        end
        if (seen.led_green !== due.led_green) begin
          $error("led_green: expected %0d, got %0d", due.led_green, seen.led_green);
          errors++;
        end
        if (seen.selecting !== due.selecting) begin
          $error("selecting: expected %0d, got %0d", due.selecting, seen.selecting);
          errors++;
        end
        if (seen.soft_reset !== due.soft_reset) begin
          $error("soft_reset: expected %0d, got %0d", due.soft_reset, seen.soft_reset);
          errors++;
        end
        if (seen.hard_reset !== due.hard_reset) begin
          $error("hard_reset: expected %0d, got %0d", due.hard_reset, seen.hard_reset);
          errors++;
        end
      end
    end
  end

endmodule
